// File: src/dcwf_pkg.sv
// shared constants, types and helper functions for the composition window filter
`default_nettype none

package dcwf_pkg;

	localparam int MAX_PATTERN = 256;
	localparam int HIST_AW     = $clog2(MAX_PATTERN);
	localparam int LEN_W       = $clog2(MAX_PATTERN) + 1;
	localparam int CNT_W       = 9;
	localparam int SCORE_W     = CNT_W + 2;
	localparam int POS_W       = 32;
	localparam int CFG_W       = 9;
	localparam int ADDR_W      = 5;
	localparam int FIFO_DEPTH  = 8;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW     = FIFO_AW + 1;
	localparam int OCC_W       = FIFO_CW + 1;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef logic [2:0] code_t;
	localparam code_t CODE_OTHER = 3'd0;
	localparam code_t CODE_A     = 3'd1;
	localparam code_t CODE_C     = 3'd2;
	localparam code_t CODE_G     = 3'd3;
	localparam code_t CODE_T     = 3'd4;

	localparam logic [7:0] ASCII_A = 8'h41;
	localparam logic [7:0] ASCII_C = 8'h43;
	localparam logic [7:0] ASCII_G = 8'h47;
	localparam logic [7:0] ASCII_T = 8'h54;

	// register index, taken from paddr[4:2]
	typedef enum logic [2:0] {
		REG_PAT_A     = 3'd0,
		REG_PAT_C     = 3'd1,
		REG_PAT_G     = 3'd2,
		REG_PAT_T     = 3'd3,
		REG_LENGTH    = 3'd4,
		REG_MIN_SCORE = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [POS_W-1:0] block_start;
		logic [POS_W-1:0] block_end;
		logic             found;
		logic             final_block;
	} result_t;

	function automatic code_t code_of(input logic [7:0] b);
		code_t c;
		unique case (b)
			ASCII_A: c = CODE_A;
			ASCII_C: c = CODE_C;
			ASCII_G: c = CODE_G;
			ASCII_T: c = CODE_T;
			default: c = CODE_OTHER;
		endcase
		return c;
	endfunction

	// length register clamped to 1 .. MAX_PATTERN
	function automatic logic [LEN_W-1:0] len_eff(input logic [CFG_W-1:0] r);
		logic [LEN_W-1:0] l;
		if (r == '0) begin
			l = LEN_W'(1);
		end else if (r > CFG_W'(MAX_PATTERN)) begin
			l = LEN_W'(MAX_PATTERN);
		end else begin
			l = LEN_W'(r);
		end
		return l;
	endfunction

endpackage

`default_nettype wire

// File: src/dcwf_if.sv
// stream interfaces for text words in and block words out
`default_nettype none

interface dcwf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] base;
	logic       end_of_text;

	modport source (output valid, output base, output end_of_text, input ready);
	modport sink (input valid, input base, input end_of_text, output ready);
endinterface

interface dcwf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] block_start;
	logic [31:0] block_end;
	logic        found;
	logic        final_block;

	modport source (output valid, output block_start, output block_end, output found,
		output final_block, input ready);
	modport sink (input valid, input block_start, input block_end, input found,
		input final_block, output ready);
endinterface

`default_nettype wire

// File: src/dna_composition_window_filter.sv
// sliding window base composition filter: counts, scoring, block merge, result queue
// a result word passes the stage 1 and stage 2 registers and the result queue before it is offered
// throughput: one text word per cycle while the result queue has room, set by the combinational count update and
// the registered history read prefetched for the next word
// arst_n clears counts, positions, block state, queue and pipeline valids;
// the 256-entry history memory is not cleared and needs no clearing pass
`default_nettype none

module dna_composition_window_filter
	import dcwf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	dcwf_in_if.sink           text_ch,
	dcwf_out_if.source        block_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// configuration
	logic [CFG_W-1:0] pat_q [4];
	logic [CFG_W-1:0] len_q;
	logic [CFG_W-1:0] min_q;
	logic             cfg_wr;
	logic [2:0]       cfg_idx;
	logic [LEN_W-1:0] len_cur;
	logic [LEN_W-1:0] len_nx;

	// text state
	code_t            hist_mem [MAX_PATTERN];
	code_t            old_q;
	logic [HIST_AW-1:0] ptr_q;
	logic [HIST_AW-1:0] ptr_nx;
	logic [HIST_AW-1:0] rd_addr;
	logic [CNT_W-1:0] cnt_q [4];
	logic [CNT_W-1:0] cnt_upd [4];
	logic [LEN_W-1:0] fill_q;
	logic [LEN_W-1:0] fill_upd;
	logic [POS_W-1:0] pos_q;
	logic             acc;
	logic             last;
	code_t            code;
	logic             full_pre;
	logic             win_ok;
	logic [POS_W-1:0] p_cur;

	// stage 1: scoring
	logic             v_s1;
	logic [CNT_W-1:0] cnt_s1 [4];
	logic             win_s1;
	logic [POS_W-1:0] p_s1;
	logic             last_s1;
	logic [SCORE_W-1:0] score;
	logic             hit;

	// stage 2: block merge
	logic             v_s2;
	logic             hit_s2;
	logic [POS_W-1:0] p_s2;
	logic             last_s2;
	logic             open_q;
	logic [POS_W-1:0] start_q;
	logic [POS_W-1:0] prev_q;
	logic             emit_mid;
	logic             open_n;
	logic [POS_W-1:0] start_n;
	logic [POS_W-1:0] prev_n;
	result_t          res_mid;
	result_t          res_fin;

	// result queue
	result_t          fifo_mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q;
	logic [FIFO_AW-1:0] rp_q;
	logic [FIFO_CW-1:0] fcnt_q;
	logic [1:0]       push_n;
	logic             pop;
	logic [OCC_W-1:0] occ;
	result_t          head;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[4:2];
	assign len_cur = len_eff(len_q);

	always_comb begin
		len_nx = len_cur;
		if (cfg_wr && cfg_idx == REG_LENGTH) begin
			len_nx = len_eff(pwdata[CFG_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				pat_q[i] <= '0;
			end
			len_q <= CFG_W'(1);
			min_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_PAT_A:     pat_q[0] <= pwdata[CFG_W-1:0];
				REG_PAT_C:     pat_q[1] <= pwdata[CFG_W-1:0];
				REG_PAT_G:     pat_q[2] <= pwdata[CFG_W-1:0];
				REG_PAT_T:     pat_q[3] <= pwdata[CFG_W-1:0];
				REG_LENGTH:    len_q    <= pwdata[CFG_W-1:0];
				REG_MIN_SCORE: min_q    <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_PAT_A:     prdata = 32'(pat_q[0]);
			REG_PAT_C:     prdata = 32'(pat_q[1]);
			REG_PAT_G:     prdata = 32'(pat_q[2]);
			REG_PAT_T:     prdata = 32'(pat_q[3]);
			REG_LENGTH:    prdata = 32'(len_q);
			REG_MIN_SCORE: prdata = 32'(min_q);
			default:       prdata = '0;
		endcase
	end

	// ---------------- window update ----------------
	assign acc      = text_ch.valid & text_ch.ready;
	assign last     = text_ch.end_of_text;
	assign code     = code_of(text_ch.base);
	assign full_pre = fill_q >= len_cur;
	assign fill_upd = full_pre ? fill_q : fill_q + LEN_W'(1);
	assign win_ok   = fill_upd >= len_cur;
	assign p_cur    = pos_q + POS_W'(1) - POS_W'(len_cur);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			cnt_upd[i] = cnt_q[i];
			if (full_pre && old_q == code_t'(i + 1) && cnt_q[i] != '0) begin
				cnt_upd[i] = cnt_q[i] - CNT_W'(1);
			end
			if (code == code_t'(i + 1) && cnt_upd[i] != CNT_MAX) begin
				cnt_upd[i] = cnt_upd[i] + CNT_W'(1);
			end
		end
	end

	// prefetch the base code that leaves the window for the next word
	always_comb begin
		ptr_nx = ptr_q;
		if (acc) begin
			ptr_nx = last ? '0 : ptr_q + HIST_AW'(1);
		end
	end
	assign rd_addr = ptr_nx - HIST_AW'(len_nx);

	always_ff @(posedge clk) begin
		if (acc) begin
			hist_mem[ptr_q] <= code;
		end
		if (acc && rd_addr == ptr_q) begin
			old_q <= code;
		end else begin
			old_q <= hist_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
			pos_q  <= '0;
			for (int i = 0; i < 4; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (acc) begin
			ptr_q <= ptr_nx;
			if (last) begin
				fill_q <= '0;
				pos_q  <= '0;
				for (int i = 0; i < 4; i++) begin
					cnt_q[i] <= '0;
				end
			end else begin
				fill_q <= fill_upd;
				pos_q  <= pos_q + POS_W'(1);
				for (int i = 0; i < 4; i++) begin
					cnt_q[i] <= cnt_upd[i];
				end
			end
		end
	end

	// ---------------- stage 1: score ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < 4; i++) begin
				cnt_s1[i] <= cnt_upd[i];
			end
			win_s1  <= win_ok;
			p_s1    <= p_cur;
			last_s1 <= last;
		end
	end

	always_comb begin
		score = '0;
		for (int i = 0; i < 4; i++) begin
			score = score + SCORE_W'((cnt_s1[i] < pat_q[i]) ? cnt_s1[i] : pat_q[i]);
		end
	end
	assign hit = win_s1 && (score >= SCORE_W'(min_q));

	// ---------------- stage 2: block merge ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			hit_s2  <= hit;
			p_s2    <= p_s1;
			last_s2 <= last_s1;
		end
	end

	assign emit_mid = hit_s2 && open_q && ((p_s2 - prev_q) > POS_W'(len_cur));
	assign open_n   = open_q | hit_s2;
	assign start_n  = (hit_s2 && (!open_q || emit_mid)) ? p_s2 : start_q;
	assign prev_n   = hit_s2 ? p_s2 : prev_q;

	always_comb begin
		res_mid.block_start = start_q;
		res_mid.block_end   = prev_q;
		res_mid.found       = 1'b1;
		res_mid.final_block = 1'b0;
		res_fin.block_start = open_n ? start_n : '0;
		res_fin.block_end   = open_n ? prev_n : '0;
		res_fin.found       = open_n;
		res_fin.final_block = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			start_q <= '0;
			prev_q  <= '0;
		end else if (v_s2) begin
			if (last_s2) begin
				open_q  <= 1'b0;
				start_q <= '0;
				prev_q  <= '0;
			end else begin
				open_q  <= open_n;
				start_q <= start_n;
				prev_q  <= prev_n;
			end
		end
	end

	// ---------------- result queue ----------------
	assign push_n = v_s2 ? ({1'b0, emit_mid} + {1'b0, last_s2}) : 2'd0;
	assign pop    = block_ch.valid & block_ch.ready;

	always_ff @(posedge clk) begin
		if (v_s2 && emit_mid) begin
			fifo_mem[wp_q] <= res_mid;
		end
		if (v_s2 && last_s2) begin
			fifo_mem[wp_q + FIFO_AW'(emit_mid)] <= res_fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fcnt_q <= '0;
		end else begin
			wp_q   <= wp_q + FIFO_AW'(push_n);
			rp_q   <= rp_q + FIFO_AW'(pop);
			fcnt_q <= fcnt_q + FIFO_CW'(push_n) - FIFO_CW'(pop);
		end
	end

	// room for two words from each word in flight and from the new one
	assign occ = OCC_W'(fcnt_q) + {{(OCC_W-2){1'b0}}, v_s1, 1'b0}
		+ {{(OCC_W-2){1'b0}}, v_s2, 1'b0};
	assign text_ch.ready = occ <= OCC_W'(FIFO_DEPTH - 2);

	assign head                 = fifo_mem[rp_q];
	assign block_ch.valid       = fcnt_q != '0;
	assign block_ch.block_start = head.block_start;
	assign block_ch.block_end   = head.block_end;
	assign block_ch.found       = head.found;
	assign block_ch.final_block = head.final_block;

endmodule

`default_nettype wire

// File: test/dcwf_block_checker.sv
// checker: predicts merged hit blocks from text and register writes, compares block words
`timescale 1ns / 100ps

module dcwf_block_checker
	import dcwf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	dcwf_in_if                text_ch,
	dcwf_out_if               block_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                mismatches,
	output int                outstanding
);

	logic [CFG_W-1:0]   pat_count [4];
	logic [CFG_W-1:0]   len_reg;
	logic [CFG_W-1:0]   min_score;
	code_t              history [MAX_PATTERN];
	logic [HIST_AW-1:0] hist_ptr;
	logic [CNT_W-1:0]   win_count [4];
	logic [LEN_W-1:0]   win_fill;
	logic [POS_W-1:0]   text_pos;
	logic               blk_open;
	logic [POS_W-1:0]   blk_start;
	logic [POS_W-1:0]   last_hit;
	result_t            expected_blocks [$];
	int                 fails;

	task automatic clear_text();
		hist_ptr = '0;
		for (int i = 0; i < 4; i++) win_count[i] = '0;
		win_fill = '0;
		text_pos = '0;
		blk_open = 1'b0;
		blk_start = '0;
		last_hit = '0;
	endtask

	task automatic queue_block(input logic [POS_W-1:0] s, input logic [POS_W-1:0] e,
		input logic hit, input logic fin);
		result_t r;
		r.block_start = s;
		r.block_end = e;
		r.found = hit;
		r.final_block = fin;
		expected_blocks.insert(expected_blocks.size(), r);
	endtask

	// one text word: window update, scoring, block merge, end of text
	task automatic take_base(input logic [7:0] b, input logic last);
		int unsigned eff_len;
		int unsigned score;
		int          k;
		code_t       c;
		code_t       old;
		logic [POS_W-1:0] p;
		eff_len = (len_reg == '0) ? 1 :
			((len_reg > CFG_W'(MAX_PATTERN)) ? MAX_PATTERN : int'(len_reg));
		case (b)
			ASCII_A: c = CODE_A;
			ASCII_C: c = CODE_C;
			ASCII_G: c = CODE_G;
			ASCII_T: c = CODE_T;
			default: c = CODE_OTHER;
		endcase
		if (win_fill >= eff_len) begin
			old = history[(int'(hist_ptr) + MAX_PATTERN - eff_len) % MAX_PATTERN];
			if (old != CODE_OTHER) begin
				k = int'(old) - 1;
				if (win_count[k] != '0) win_count[k] = win_count[k] - 1'b1;
			end
		end else begin
			win_fill = win_fill + 1'b1;
		end
		history[hist_ptr] = c;
		hist_ptr = hist_ptr + 1'b1;
		if (c != CODE_OTHER) begin
			k = int'(c) - 1;
			if (win_count[k] != CNT_MAX) win_count[k] = win_count[k] + 1'b1;
		end
		if (win_fill >= eff_len) begin
			score = 0;
			for (int i = 0; i < 4; i++)
				score += (win_count[i] < pat_count[i]) ? win_count[i] : pat_count[i];
			p = text_pos + 1 - POS_W'(eff_len);
			if (score >= min_score) begin
				if (!blk_open) begin
					blk_open = 1'b1;
					blk_start = p;
				end else if (POS_W'(p - last_hit) > eff_len) begin
					queue_block(blk_start, last_hit, 1'b1, 1'b0);
					blk_start = p;
				end
				last_hit = p;
			end
		end
		text_pos = text_pos + 1'b1;
		if (last) begin
			if (blk_open) queue_block(blk_start, last_hit, 1'b1, 1'b1);
			else queue_block('0, '0, 1'b0, 1'b1);
			clear_text();
		end
	endtask

	task automatic note_mismatch(input string what, input result_t want, input result_t got);
		fails++;
		if (fails <= 10)
			$display({"block word mismatch (%s): expected start %0d end %0d found %0b",
				" final %0b, got start %0d end %0d found %0b final %0b"},
				what, want.block_start, want.block_end, want.found, want.final_block,
				got.block_start, got.block_end, got.found, got.final_block);
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		result_t got;
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) pat_count[i] = '0;
			len_reg = CFG_W'(1);
			min_score = '0;
			for (int i = 0; i < MAX_PATTERN; i++) history[i] = CODE_OTHER;
			clear_text();
			expected_blocks.delete();
			fails = 0;
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_PAT_A:     pat_count[0] = pwdata[CFG_W-1:0];
					REG_PAT_C:     pat_count[1] = pwdata[CFG_W-1:0];
					REG_PAT_G:     pat_count[2] = pwdata[CFG_W-1:0];
					REG_PAT_T:     pat_count[3] = pwdata[CFG_W-1:0];
					REG_LENGTH:    len_reg = pwdata[CFG_W-1:0];
					REG_MIN_SCORE: min_score = pwdata[CFG_W-1:0];
					default: ;
				endcase
			end
			if (text_ch.valid && text_ch.ready)
				take_base(text_ch.base, text_ch.end_of_text);
			if (block_ch.valid && block_ch.ready) begin
				got.block_start = block_ch.block_start;
				got.block_end = block_ch.block_end;
				got.found = block_ch.found;
				got.final_block = block_ch.final_block;
				if (expected_blocks.size() == 0) begin
					note_mismatch("no word expected", '0, got);
				end else begin
					want = expected_blocks.pop_front();
					if (got !== want) note_mismatch("wrong field", want, got);
				end
			end
			outstanding <= expected_blocks.size();
			mismatches <= fails;
		end
	end

endmodule

// File: test/tb_dna_composition_window_filter.sv
// testbench top: drives text words and register writes, paces both sides, gives the verdict
`timescale 1ns / 100ps

module tb_dna_composition_window_filter
	import dcwf_pkg::*;
;

	localparam int TEXT_WORDS  = 1550;
	localparam int CYCLE_LIMIT = 500000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              pace = 1'b1;
	int                words_sent = 0;
	int                cycles = 0;
	int                mismatches;
	int                outstanding;

	dcwf_in_if  text_ch ();
	dcwf_out_if block_ch ();

	dna_composition_window_filter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.text_ch  (text_ch),
		.block_ch (block_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	dcwf_block_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_ch     (text_ch),
		.block_ch    (block_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [7:0] base_letter(input int unsigned k);
		case (k)
			0: return ASCII_A;
			1: return ASCII_C;
			2: return ASCII_G;
			default: return ASCII_T;
		endcase
	endfunction

	task automatic send_word(input logic [7:0] b, input logic last);
		int gap;
		gap = pace ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.base <= b;
		text_ch.end_of_text <= last;
		do @(posedge clk); while (!text_ch.ready);
		words_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
	endtask

	// hold the text until every block word is back, then let the pipeline settle
	task automatic drain_results();
		text_ch.valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({idx, 2'b00});
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] c,
		input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] t,
		input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] min_sc);
		write_reg(REG_PAT_A, a);
		write_reg(REG_PAT_C, c);
		write_reg(REG_PAT_G, g);
		write_reg(REG_PAT_T, t);
		write_reg(REG_LENGTH, len);
		write_reg(REG_MIN_SCORE, min_sc);
	endtask

	// result side: random stall before each word, sometimes none
	initial begin : result_sink
		int stall;
		block_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = pace ? $urandom_range(0, 8) : 0;
			if (stall > 0) begin
				block_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			block_ch.ready <= 1'b1;
			do @(posedge clk); while (!block_ch.valid);
		end
	end

	initial begin : stimulus
		logic [7:0]       motif [MAX_PATTERN];
		int unsigned      comp [4];
		logic [CFG_W-1:0] len_reg;
		logic [CFG_W-1:0] cnt_reg [4];
		logic [CFG_W-1:0] min_reg;
		int unsigned      eff_len;
		int unsigned      motif_pos;
		int unsigned      pick;
		int               sel;
		int               floor_score;
		int               text_left;
		int               phase_left;
		logic [7:0]       b;

		text_ch.valid <= 1'b0;
		text_ch.base <= 8'h00;
		text_ch.end_of_text <= 1'b0;
		eff_len = 1;
		motif_pos = 0;
		text_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every window is a hit, one merged block
		send_text("ACGT");
		send_word(8'hFF, 1'b1);
		drain_results();
		// two distant hits give a middle block, then a text shorter than the window
		configure(9'd2, 9'd1, 9'd1, 9'd0, 9'd4, 9'd4);
		send_text("AACGTTTTTTGACA");
		send_text("AC");
		drain_results();
		// zero length acts as one, unreachable score
		configure(9'd511, 9'd511, 9'd511, 9'd511, 9'd0, 9'd511);
		send_word(8'h00, 1'b0);
		send_word(ASCII_T, 1'b1);
		drain_results();
		// oversized length clamps to the full history
		configure(9'd0, 9'd0, 9'd0, 9'd0, 9'd300, 9'd0);
		send_word(ASCII_G, 1'b1);

		while (words_sent < TEXT_WORDS) begin
			drain_results();
			pace = ($urandom_range(0, 3) != 0);
			sel = $urandom_range(0, 19);
			if (sel < 13) len_reg = CFG_W'($urandom_range(1, 12));
			else if (sel < 16) len_reg = CFG_W'($urandom_range(13, 64));
			else if (sel == 16) len_reg = CFG_W'(256);
			else if (sel == 17) len_reg = '0;
			else len_reg = CFG_W'($urandom_range(257, 511));
			eff_len = (len_reg == '0) ? 1 : ((len_reg > CFG_W'(256)) ? 256 : int'(len_reg));
			// the pattern is a random motif; its composition sets the counts
			for (int k = 0; k < 4; k++) comp[k] = 0;
			for (int k = 0; k < eff_len; k++) begin
				pick = $urandom_range(0, 3);
				motif[k] = base_letter(pick);
				comp[pick]++;
			end
			sel = $urandom_range(0, 19);
			for (int k = 0; k < 4; k++) begin
				if (sel == 0) cnt_reg[k] = CFG_W'(511);
				else if (sel == 1) cnt_reg[k] = '0;
				else if (sel < 4) cnt_reg[k] = CFG_W'($urandom_range(0, 511));
				else cnt_reg[k] = CFG_W'(comp[k]);
			end
			sel = $urandom_range(0, 19);
			if (sel < 14) begin
				floor_score = int'(eff_len) - int'($urandom_range(0, eff_len / 3 + 1));
				min_reg = (floor_score < 0) ? '0 : CFG_W'(floor_score);
			end else if (sel < 16) begin
				min_reg = '0;
			end else if (sel < 18) begin
				min_reg = CFG_W'(511);
			end else begin
				min_reg = CFG_W'($urandom_range(0, 511));
			end
			configure(cnt_reg[0], cnt_reg[1], cnt_reg[2], cnt_reg[3], len_reg, min_reg);

			// texts run across phases, so the length also changes mid-text
			phase_left = $urandom_range(40, 160);
			while (phase_left > 0 && words_sent < TEXT_WORDS) begin
				if (text_left == 0) text_left = $urandom_range(1, 2 * eff_len + 30);
				text_left--;
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					b = motif[motif_pos % eff_len];
					motif_pos++;
				end else if (pick < 90) begin
					b = base_letter($urandom_range(0, 3));
				end else begin
					b = 8'($urandom_range(0, 255));
				end
				send_word(b, text_left == 0);
				phase_left--;
			end
		end
		if (text_left != 0) send_word(ASCII_G, 1'b1);
		drain_results();
		repeat (12) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
